// ===== rtl/rcrp_pkg.sv =====
// Package for the compound RTCP report parser: packet type codes, field offsets,
// record struct and kind decode. No dependencies.
`default_nettype none

package rcrp_pkg;

  // RTCP packet type codes
  localparam logic [7:0] PT_SR   = 8'd200;
  localparam logic [7:0] PT_RR   = 8'd201;
  localparam logic [7:0] PT_SDES = 8'd202;
  localparam logic [7:0] PT_BYE  = 8'd203;
  localparam logic [7:0] PT_APP  = 8'd204;

  // SDES item type for CNAME
  localparam logic [7:0] SDES_CNAME = 8'd1;

  // header count field mask
  localparam logic [7:0] COUNT_MASK = 8'h1f;

  localparam int OFF_W = 19;
  localparam int WORDS = 8;
  localparam int WORD_IDX_W = 3;

  // byte offsets within a sub-packet
  localparam logic [OFF_W-1:0] OFF_COUNT    = 19'd0;
  localparam logic [OFF_W-1:0] OFF_TYPE     = 19'd1;
  localparam logic [OFF_W-1:0] OFF_LEN_HI   = 19'd2;
  localparam logic [OFF_W-1:0] OFF_LEN_LO   = 19'd3;
  localparam logic [OFF_W-1:0] OFF_SR_PKTS  = 19'd20;
  localparam logic [OFF_W-1:0] OFF_SR_OCTS  = 19'd24;
  localparam logic [OFF_W-1:0] OFF_SR_END   = 19'd28;
  localparam logic [OFF_W-1:0] OFF_SR_BLOCK = 19'd32;
  localparam logic [OFF_W-1:0] OFF_RR_BLOCK = 19'd12;
  localparam logic [OFF_W-1:0] BLOCK_BYTES  = 19'd20;
  localparam logic [OFF_W-1:0] OFF_SSRC     = 19'd4;
  localparam logic [OFF_W-1:0] OFF_ITEM     = 19'd8;

  // stats word slots
  localparam logic [WORD_IDX_W-1:0] W_PKTS  = 3'd0;
  localparam logic [WORD_IDX_W-1:0] W_OCTS  = 3'd1;
  localparam logic [WORD_IDX_W-1:0] W_LOSS  = 3'd2;
  localparam logic [WORD_IDX_W-1:0] W_HIGH  = 3'd3;
  localparam logic [WORD_IDX_W-1:0] W_JIT   = 3'd4;
  localparam logic [WORD_IDX_W-1:0] W_LSR   = 3'd5;
  localparam logic [WORD_IDX_W-1:0] W_DLSR  = 3'd6;
  localparam logic [WORD_IDX_W-1:0] W_CNAME = 3'd7;

  typedef enum logic [2:0] {
    KIND_SR      = 3'd0,
    KIND_RR      = 3'd1,
    KIND_SDES    = 3'd2,
    KIND_BYE     = 3'd3,
    KIND_APP     = 3'd4,
    KIND_UNKNOWN = 3'd5
  } rcrp_kind_t;

  // one stats record
  typedef struct packed {
    rcrp_kind_t  kind;
    logic [31:0] sender_packets;
    logic [31:0] sender_octets;
    logic [7:0]  fraction_lost;
    logic [23:0] cumulative_lost;
    logic [31:0] highest_sequence;
    logic [31:0] arrival_jitter;
    logic [31:0] last_report_stamp;
    logic [31:0] delay_since_report;
    logic [31:0] cname_source;
    logic [31:0] sr_seen;
    logic [31:0] rr_seen;
  } rcrp_rec_t;

  // map a packet type byte to its kind
  function automatic rcrp_kind_t kind_of(logic [7:0] t);
    logic [7:0] d;
    d = t - PT_SR;
    if (t >= PT_SR && t <= PT_APP) begin
      return rcrp_kind_t'(d[2:0]);
    end
    return KIND_UNKNOWN;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rtcp_compound_report_parser.sv =====
// Top level of the compound RTCP report parser: input register, walker and
// result register. Depends on rcrp_pkg and rcrp_walker.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   input   | in_valid, in_ready, in_packet_byte,    | in
//           | in_last_byte                           |
//   result  | out_valid, out_ready, out_packet_kind  | out
//           | and the eleven stats fields            |
//
// one byte a cycle sustained while no record is blocked; a byte's record passes the input
// register, and is loaded into the result register when the walker steps on that byte.
// the input register and result register let a new beat in while a record waits.
// a byte that produces a record stalls only while the result register is full
// and not taken; bytes with no record are never stalled.
// synchronous reset clears counters, stats words and both valid flags.
`default_nettype none

module rtcp_compound_report_parser (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_packet_byte,
  input  wire         in_last_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  out_packet_kind,
  output logic [31:0] out_sender_packets,
  output logic [31:0] out_sender_octets,
  output logic [7:0]  out_fraction_lost,
  output logic [23:0] out_cumulative_lost,
  output logic [31:0] out_highest_sequence,
  output logic [31:0] out_arrival_jitter,
  output logic [31:0] out_last_report_stamp,
  output logic [31:0] out_delay_since_report,
  output logic [31:0] out_cname_source,
  output logic [31:0] out_sender_reports_seen,
  output logic [31:0] out_receiver_reports_seen
);

  logic                in_valid_r, in_valid_nxt;
  logic [7:0]          in_byte_r;
  logic                in_last_r;
  logic                out_valid_r, out_valid_nxt;
  rcrp_pkg::rcrp_rec_t rec_r;
  rcrp_pkg::rcrp_rec_t rec;
  logic                emit;
  logic                step;

  rcrp_walker u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .pkt_byte (in_byte_r),
    .last     (in_last_r),
    .emit     (emit),
    .rec      (rec)
  );

  // handshake control
  always_comb begin
    step          = in_valid_r && (!emit || !out_valid_r || out_ready);
    in_ready      = !in_valid_r || step;
    in_valid_nxt  = in_ready ? in_valid : in_valid_r;
    out_valid_nxt = (step && emit) ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_packet_byte;
      in_last_r <= in_last_byte;
    end
    if (step && emit) begin
      rec_r <= rec;
    end
  end

  // result ports
  always_comb begin
    out_valid                 = out_valid_r;
    out_packet_kind           = rec_r.kind;
    out_sender_packets        = rec_r.sender_packets;
    out_sender_octets         = rec_r.sender_octets;
    out_fraction_lost         = rec_r.fraction_lost;
    out_cumulative_lost       = rec_r.cumulative_lost;
    out_highest_sequence      = rec_r.highest_sequence;
    out_arrival_jitter        = rec_r.arrival_jitter;
    out_last_report_stamp     = rec_r.last_report_stamp;
    out_delay_since_report    = rec_r.delay_since_report;
    out_cname_source          = rec_r.cname_source;
    out_sender_reports_seen   = rec_r.sr_seen;
    out_receiver_reports_seen = rec_r.rr_seen;
  end

  // input stalls only behind a full, untaken result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready && emit))
    else $error("input stalled without a blocked record");

  // a taken record with nothing new behind it empties the result register
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !(step && emit)) |=> !out_valid_r)
    else $error("record repeated");

  // a new record always shows valid next cycle
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (step && emit) |=> out_valid_r)
    else $error("record lost");

endmodule

`default_nettype wire

// ===== rtl/rcrp_walker.sv =====
// Sub-packet walker: offset tracking, field captures and record build.
// Depends on rcrp_pkg.
`default_nettype none

module rcrp_walker (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  step,
  input  wire [7:0]            pkt_byte,
  input  wire                  last,
  output logic                 emit,
  output rcrp_pkg::rcrp_rec_t  rec
);

  localparam int OW = rcrp_pkg::OFF_W;

  logic [OW-1:0] off_r, off_nxt;
  logic [OW-1:0] sb_r, sb_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [4:0]    count_r, count_nxt;
  logic          skip_r, skip_nxt;
  logic [31:0]   sw_r   [rcrp_pkg::WORDS];
  logic [31:0]   sw_nxt [rcrp_pkg::WORDS];
  logic [31:0]   sr_r, sr_nxt;
  logic [31:0]   rr_r, rr_nxt;
  logic [31:0]   src_r, src_nxt;

  logic [OW-1:0] blk_base;
  logic [OW-1:0] blk_rel;
  logic          blk_hit;
  logic [OW:0]   off_inc;
  logic [16:0]   len_words;
  logic          done;

  // report block window for the current sub-packet type
  always_comb begin
    blk_base = (type_r == rcrp_pkg::PT_SR) ? rcrp_pkg::OFF_SR_BLOCK
                                            : rcrp_pkg::OFF_RR_BLOCK;
    blk_rel  = off_r - blk_base;
    blk_hit  = (count_r != 5'd0) && (off_r >= blk_base) &&
               (off_r < blk_base + rcrp_pkg::BLOCK_BYTES) &&
               ((type_r == rcrp_pkg::PT_SR) || (type_r == rcrp_pkg::PT_RR));
    off_inc  = {1'b0, off_r} + {{OW{1'b0}}, 1'b1};
    len_words = {1'b0, sb_r[15:8], pkt_byte} + 17'd1;
  end

  // next state for one byte
  always_comb begin
    off_nxt   = off_r;
    sb_nxt    = sb_r;
    type_nxt  = type_r;
    count_nxt = count_r;
    skip_nxt  = skip_r;
    sw_nxt    = sw_r;
    sr_nxt    = sr_r;
    rr_nxt    = rr_r;
    src_nxt   = src_r;
    emit      = 1'b0;
    done      = 1'b0;

    if (skip_r) begin
      // drop bytes until the end of the compound packet
      if (last) begin
        skip_nxt = 1'b0;
        off_nxt  = '0;
      end
    end else if (off_r == rcrp_pkg::OFF_TYPE &&
                 rcrp_pkg::kind_of(pkt_byte) == rcrp_pkg::KIND_UNKNOWN) begin
      // unknown type: report it and skip the rest
      type_nxt = pkt_byte;
      emit     = 1'b1;
      if (last) begin
        off_nxt = '0;
      end else begin
        skip_nxt = 1'b1;
      end
    end else begin
      if (off_r == rcrp_pkg::OFF_COUNT) begin
        count_nxt = pkt_byte[4:0] & rcrp_pkg::COUNT_MASK[4:0];
      end else if (off_r == rcrp_pkg::OFF_TYPE) begin
        type_nxt = pkt_byte;
        if (pkt_byte == rcrp_pkg::PT_SR) begin
          sr_nxt = sr_r + 32'd1;
        end else if (pkt_byte == rcrp_pkg::PT_RR) begin
          rr_nxt = rr_r + 32'd1;
        end
      end else if (off_r == rcrp_pkg::OFF_LEN_HI) begin
        sb_nxt = {3'b000, pkt_byte, 8'h00};
      end else if (off_r == rcrp_pkg::OFF_LEN_LO) begin
        sb_nxt = {len_words, 2'b00};
      end else begin
        // sender info
        if (type_r == rcrp_pkg::PT_SR) begin
          if (off_r >= rcrp_pkg::OFF_SR_PKTS && off_r < rcrp_pkg::OFF_SR_OCTS) begin
            sw_nxt[rcrp_pkg::W_PKTS] = {sw_r[rcrp_pkg::W_PKTS][23:0], pkt_byte};
          end else if (off_r >= rcrp_pkg::OFF_SR_OCTS && off_r < rcrp_pkg::OFF_SR_END) begin
            sw_nxt[rcrp_pkg::W_OCTS] = {sw_r[rcrp_pkg::W_OCTS][23:0], pkt_byte};
          end
        end
        // first report block, one word every four bytes
        for (int k = 2; k < 7; k++) begin
          if (blk_hit && blk_rel[4:2] == 3'(k - 2)) begin
            sw_nxt[k] = {sw_r[k][23:0], pkt_byte};
          end
        end
        // sdes chunk source and first item
        if (type_r == rcrp_pkg::PT_SDES && count_r != 5'd0) begin
          if (off_r >= rcrp_pkg::OFF_SSRC && off_r < rcrp_pkg::OFF_ITEM) begin
            src_nxt = {src_r[23:0], pkt_byte};
          end else if (off_r == rcrp_pkg::OFF_ITEM && pkt_byte == rcrp_pkg::SDES_CNAME) begin
            sw_nxt[rcrp_pkg::W_CNAME] = src_r;
          end
        end
      end

      // end of sub-packet
      done = (off_r >= rcrp_pkg::OFF_LEN_LO) && (off_inc >= {1'b0, sb_nxt});
      off_nxt = (done || last) ? '0 : off_inc[OW-1:0];
      emit = done || (last && off_r >= rcrp_pkg::OFF_TYPE);
    end
  end

  // record as seen after this byte
  always_comb begin
    rec.kind               = rcrp_pkg::kind_of(type_nxt);
    rec.sender_packets     = sw_nxt[rcrp_pkg::W_PKTS];
    rec.sender_octets      = sw_nxt[rcrp_pkg::W_OCTS];
    rec.fraction_lost      = sw_nxt[rcrp_pkg::W_LOSS][31:24];
    rec.cumulative_lost    = sw_nxt[rcrp_pkg::W_LOSS][23:0];
    rec.highest_sequence   = sw_nxt[rcrp_pkg::W_HIGH];
    rec.arrival_jitter     = sw_nxt[rcrp_pkg::W_JIT];
    rec.last_report_stamp  = sw_nxt[rcrp_pkg::W_LSR];
    rec.delay_since_report = sw_nxt[rcrp_pkg::W_DLSR];
    rec.cname_source       = sw_nxt[rcrp_pkg::W_CNAME];
    rec.sr_seen            = sr_nxt;
    rec.rr_seen            = rr_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      sb_r    <= '0;
      type_r  <= '0;
      count_r <= '0;
      skip_r  <= 1'b0;
      sr_r    <= '0;
      rr_r    <= '0;
      src_r   <= '0;
      for (int i = 0; i < rcrp_pkg::WORDS; i++) begin
        sw_r[i] <= '0;
      end
    end else if (step) begin
      off_r   <= off_nxt;
      sb_r    <= sb_nxt;
      type_r  <= type_nxt;
      count_r <= count_nxt;
      skip_r  <= skip_nxt;
      sr_r    <= sr_nxt;
      rr_r    <= rr_nxt;
      src_r   <= src_nxt;
      sw_r    <= sw_nxt;
    end
  end

  // skipping only starts from the type byte
  a_skip_off: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> off_r == rcrp_pkg::OFF_TYPE)
    else $error("skip set away from type offset");

  // length is known once past the header
  a_len_set: assert property (@(posedge clk) disable iff (!rst_n)
    (!skip_r && off_r > rcrp_pkg::OFF_LEN_LO) |-> sb_r >= 19'd4)
    else $error("sub-packet length missing past header");

  // skipping holds until the final byte of the compound packet
  a_skip_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step && skip_r && !last) |=> skip_r)
    else $error("skip dropped before the final byte");

endmodule

`default_nettype wire

// ===== tb/rcrp_checker.sv =====
// Checker for the compound RTCP report parser: watches the byte and record channels,
// predicts each stats record and compares it field by field. Depends on rcrp_pkg.
`timescale 1ns / 100ps

module rcrp_checker
  import rcrp_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  input  wire         in_ready,
  input  wire  [7:0]  in_packet_byte,
  input  wire         in_last_byte,
  input  wire         out_valid,
  input  wire         out_ready,
  input  wire  [2:0]  out_packet_kind,
  input  wire  [31:0] out_sender_packets,
  input  wire  [31:0] out_sender_octets,
  input  wire  [7:0]  out_fraction_lost,
  input  wire  [23:0] out_cumulative_lost,
  input  wire  [31:0] out_highest_sequence,
  input  wire  [31:0] out_arrival_jitter,
  input  wire  [31:0] out_last_report_stamp,
  input  wire  [31:0] out_delay_since_report,
  input  wire  [31:0] out_cname_source,
  input  wire  [31:0] out_sender_reports_seen,
  input  wire  [31:0] out_receiver_reports_seen,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned records_checked
);

  // parser state as seen from outside
  int unsigned  byte_pos;
  int unsigned  sub_len;
  logic [7:0]   sub_type;
  logic [4:0]   rep_count;
  logic         skipping;
  logic [31:0]  stats [WORDS];
  logic [31:0]  chunk_ssrc;
  logic [31:0]  sr_total;
  logic [31:0]  rr_total;

  rcrp_rec_t expected_records [$];

  function automatic rcrp_kind_t kind_for(input logic [7:0] t);
    case (t)
      PT_SR:   return KIND_SR;
      PT_RR:   return KIND_RR;
      PT_SDES: return KIND_SDES;
      PT_BYE:  return KIND_BYE;
      PT_APP:  return KIND_APP;
      default: return KIND_UNKNOWN;
    endcase
  endfunction

  // snapshot of the stats words for the current sub-packet
  task automatic queue_record();
    rcrp_rec_t rec;
    rec.kind               = kind_for(sub_type);
    rec.sender_packets     = stats[W_PKTS];
    rec.sender_octets      = stats[W_OCTS];
    rec.fraction_lost      = stats[W_LOSS][31:24];
    rec.cumulative_lost    = stats[W_LOSS][23:0];
    rec.highest_sequence   = stats[W_HIGH];
    rec.arrival_jitter     = stats[W_JIT];
    rec.last_report_stamp  = stats[W_LSR];
    rec.delay_since_report = stats[W_DLSR];
    rec.cname_source       = stats[W_CNAME];
    rec.sr_seen            = sr_total;
    rec.rr_seen            = rr_total;
    expected_records.push_back(rec);
  endtask

  // shift a byte into the report block word it belongs to
  task automatic take_block_byte(input int unsigned pos, input int unsigned base,
                                 input logic [7:0] b);
    int unsigned k;
    if (rep_count != 0 && pos >= base && pos < base + BLOCK_BYTES) begin
      k = 2 + ((pos - base) >> 2);
      stats[k] = {stats[k][23:0], b};
    end
  endtask

  // advance the parser by one accepted byte
  task automatic parse_byte(input logic [7:0] b, input logic last);
    int unsigned pos;
    logic        done;
    logic        unknown;
    pos = byte_pos;
    done = 1'b0;
    unknown = 1'b0;
    if (skipping) begin
      // rest of the compound packet after an unknown type
      if (last) begin
        skipping = 1'b0;
        byte_pos = 0;
      end
    end else begin
      if (pos == OFF_COUNT) begin
        rep_count = b[4:0];
      end else if (pos == OFF_TYPE) begin
        sub_type = b;
        if (b == PT_SR) sr_total = sr_total + 1;
        else if (b == PT_RR) rr_total = rr_total + 1;
        unknown = (kind_for(b) == KIND_UNKNOWN);
      end else if (pos == OFF_LEN_HI) begin
        sub_len = {b, 8'h00};
      end else if (pos == OFF_LEN_LO) begin
        sub_len = ((sub_len & 32'hff00) + b + 1) << 2;
      end else if (sub_type == PT_SR) begin
        if (pos >= OFF_SR_PKTS && pos < OFF_SR_OCTS) begin
          stats[W_PKTS] = {stats[W_PKTS][23:0], b};
        end else if (pos >= OFF_SR_OCTS && pos < OFF_SR_END) begin
          stats[W_OCTS] = {stats[W_OCTS][23:0], b};
        end
        take_block_byte(pos, OFF_SR_BLOCK, b);
      end else if (sub_type == PT_RR) begin
        take_block_byte(pos, OFF_RR_BLOCK, b);
      end else if (sub_type == PT_SDES && rep_count != 0) begin
        if (pos >= OFF_SSRC && pos < OFF_ITEM) begin
          chunk_ssrc = {chunk_ssrc[23:0], b};
        end else if (pos == OFF_ITEM && b == SDES_CNAME) begin
          stats[W_CNAME] = chunk_ssrc;
        end
      end

      if (unknown) begin
        // record right away, then drop the rest of the compound packet
        queue_record();
        if (last) byte_pos = 0;
        else skipping = 1'b1;
      end else begin
        done = (pos >= OFF_LEN_LO) && (pos + 1 >= sub_len);
        byte_pos = (done || last) ? 0 : pos + 1;
        if (done || (last && pos >= OFF_TYPE)) queue_record();
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // predict on input beats, compare on output beats
  always @(posedge clk) begin : watch
    rcrp_rec_t want;
    if (!rst_n) begin
      byte_pos = 0;
      sub_len = 0;
      sub_type = '0;
      rep_count = '0;
      skipping = 1'b0;
      foreach (stats[i]) stats[i] = '0;
      chunk_ssrc = '0;
      sr_total = '0;
      rr_total = '0;
      expected_records.delete();
      fail_count = 0;
      records_checked = 0;
    end else begin
      if (in_valid && in_ready) parse_byte(in_packet_byte, in_last_byte);
      if (out_valid && out_ready) begin
        records_checked++;
        if (expected_records.size() == 0) begin
          $display("%0t: unexpected record, expected none, got kind %0d", $time,
                   out_packet_kind);
          fail_count++;
        end else begin
          want = expected_records.pop_front();
          check_field("packet_kind", 32'(want.kind), 32'(out_packet_kind));
          check_field("sender_packets", want.sender_packets, out_sender_packets);
          check_field("sender_octets", want.sender_octets, out_sender_octets);
          check_field("fraction_lost", 32'(want.fraction_lost), 32'(out_fraction_lost));
          check_field("cumulative_lost", 32'(want.cumulative_lost),
                      32'(out_cumulative_lost));
          check_field("highest_sequence", want.highest_sequence, out_highest_sequence);
          check_field("arrival_jitter", want.arrival_jitter, out_arrival_jitter);
          check_field("last_report_stamp", want.last_report_stamp,
                      out_last_report_stamp);
          check_field("delay_since_report", want.delay_since_report,
                      out_delay_since_report);
          check_field("cname_source", want.cname_source, out_cname_source);
          check_field("sender_reports_seen", want.sr_seen, out_sender_reports_seen);
          check_field("receiver_reports_seen", want.rr_seen, out_receiver_reports_seen);
        end
      end
    end
    pending = expected_records.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the compound RTCP report parser: builds byte streams of compound
// packets, drives them with random gaps and back-pressure, and gives the verdict.
// Depends on rcrp_pkg, rtcp_compound_report_parser and rcrp_checker.
`timescale 1ns / 100ps

module tb_top;
  import rcrp_pkg::*;

  localparam int unsigned STREAM_BYTES = 1550;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_packet_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_packet_kind;
  logic [31:0] out_sender_packets;
  logic [31:0] out_sender_octets;
  logic [7:0]  out_fraction_lost;
  logic [23:0] out_cumulative_lost;
  logic [31:0] out_highest_sequence;
  logic [31:0] out_arrival_jitter;
  logic [31:0] out_last_report_stamp;
  logic [31:0] out_delay_since_report;
  logic [31:0] out_cname_source;
  logic [31:0] out_sender_reports_seen;
  logic [31:0] out_receiver_reports_seen;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned records_checked;

  beat_t       stream [$];
  beat_t       building [$];
  int unsigned beats_sent = 0;
  int unsigned packets_built = 0;
  logic        hold_off;
  logic        steady;

  // no gaps on either side in this window
  assign steady = (beats_sent >= 700) && (beats_sent < 1000);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rtcp_compound_report_parser u_dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .in_packet_byte            (in_packet_byte),
    .in_last_byte              (in_last_byte),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_packet_kind           (out_packet_kind),
    .out_sender_packets        (out_sender_packets),
    .out_sender_octets         (out_sender_octets),
    .out_fraction_lost         (out_fraction_lost),
    .out_cumulative_lost       (out_cumulative_lost),
    .out_highest_sequence      (out_highest_sequence),
    .out_arrival_jitter        (out_arrival_jitter),
    .out_last_report_stamp     (out_last_report_stamp),
    .out_delay_since_report    (out_delay_since_report),
    .out_cname_source          (out_cname_source),
    .out_sender_reports_seen   (out_sender_reports_seen),
    .out_receiver_reports_seen (out_receiver_reports_seen)
  );

  rcrp_checker u_check (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .in_packet_byte            (in_packet_byte),
    .in_last_byte              (in_last_byte),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_packet_kind           (out_packet_kind),
    .out_sender_packets        (out_sender_packets),
    .out_sender_octets         (out_sender_octets),
    .out_fraction_lost         (out_fraction_lost),
    .out_cumulative_lost       (out_cumulative_lost),
    .out_highest_sequence      (out_highest_sequence),
    .out_arrival_jitter        (out_arrival_jitter),
    .out_last_report_stamp     (out_last_report_stamp),
    .out_delay_since_report    (out_delay_since_report),
    .out_cname_source          (out_cname_source),
    .out_sender_reports_seen   (out_sender_reports_seen),
    .out_receiver_reports_seen (out_receiver_reports_seen),
    .fail_count                (fail_count),
    .pending                   (pending),
    .records_checked           (records_checked)
  );

  task automatic put_byte(input logic [7:0] d, input logic last);
    stream.push_back({d, last});
  endtask

  // one well-formed header with random body, length sometimes off the layout
  task automatic add_known_subpacket(output bit cut_short);
    logic [7:0] ptype;
    logic [7:0] len_hi;
    logic [7:0] b;
    logic [4:0] count;
    int         words;
    int         body;
    case ($urandom_range(4))
      0:       begin ptype = PT_SR;   words = 12; end
      1:       begin ptype = PT_RR;   words = 7;  end
      2:       begin ptype = PT_SDES; words = 3;  end
      3:       begin ptype = PT_BYE;  words = 1;  end
      default: begin ptype = PT_APP;  words = 3;  end
    endcase
    count = ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
    if ($urandom_range(99) < 40) words = $urandom_range(0, 15);
    len_hi = ($urandom_range(99) < 4) ? 8'($urandom_range(1, 255)) : 8'd0;
    // a huge declared length is always cut off by the end of the packet
    cut_short = (len_hi != 0);
    body = cut_short ? $urandom_range(8, 60) : words * 4;
    building.push_back({3'($urandom_range(7)), count, 1'b0});
    building.push_back({ptype, 1'b0});
    building.push_back({len_hi, 1'b0});
    building.push_back({8'(words), 1'b0});
    for (int i = 0; i < body; i++) begin
      b = 8'($urandom_range(255));
      // first item type of the chunk sits at body byte four
      if (ptype == PT_SDES && i == 4 && $urandom_range(99) < 70) b = SDES_CNAME;
      building.push_back({b, 1'b0});
    end
  endtask

  // unknown type followed by bytes the parser has to skip
  task automatic add_unknown_subpacket();
    logic [7:0] t;
    t = 8'($urandom_range(255));
    while (t >= PT_SR && t <= PT_APP) t = 8'($urandom_range(255));
    building.push_back({8'($urandom_range(255)), 1'b0});
    building.push_back({t, 1'b0});
    repeat ($urandom_range(0, 8)) building.push_back({8'($urandom_range(255)), 1'b0});
  endtask

  // one compound packet: mostly valid sub-packets, some noise and truncation
  task automatic add_compound();
    bit cut_short;
    int subs;
    int cut;
    building.delete();
    cut_short = 1'b0;
    subs = $urandom_range(1, 4);
    if ($urandom_range(99) < 5) begin
      repeat ($urandom_range(2, 40)) building.push_back({8'($urandom_range(255)), 1'b0});
    end else begin
      for (int s = 0; s < subs && !cut_short; s++) begin
        if ($urandom_range(99) < 8) begin
          add_unknown_subpacket();
          cut_short = 1'b1;
        end else begin
          add_known_subpacket(cut_short);
        end
      end
    end
    if ($urandom_range(99) < 15) begin
      cut = $urandom_range(0, building.size() - 1);
      building = building[0:cut];
    end
    building[building.size() - 1].last = 1'b1;
    foreach (building[i]) stream.push_back(building[i]);
    packets_built++;
  endtask

  // main: stimulus build, reset, byte sender, end of run
  initial begin
    int unsigned drain;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_packet_byte = 8'h00;
    in_last_byte = 1'b0;

    // empty sub-packet of each known type, max and zero counts
    put_byte(8'h80, 1'b0); put_byte(PT_SR, 1'b0);   put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0);
    put_byte(8'h9f, 1'b0); put_byte(PT_RR, 1'b0);   put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0);
    put_byte(8'h81, 1'b0); put_byte(PT_SDES, 1'b0); put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0);
    put_byte(8'h81, 1'b0); put_byte(PT_BYE, 1'b0);  put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0);
    put_byte(8'h80, 1'b0); put_byte(PT_APP, 1'b0);  put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0);
    // unknown type, then a skipped byte that ends the packet
    put_byte(8'h80, 1'b0); put_byte(8'hff, 1'b0); put_byte(8'h00, 1'b1);
    // unknown type on the final byte
    put_byte(8'h80, 1'b0); put_byte(8'h00, 1'b1);
    // packet ending on the first header byte: no record
    put_byte(8'hff, 1'b1);
    // packet ending right after the type byte
    put_byte(8'h81, 1'b0); put_byte(PT_RR, 1'b1);
    packets_built = 4;

    while (stream.size() < STREAM_BYTES) add_compound();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender: valid held until accepted, random gaps between beats
    foreach (stream[i]) begin
      @(negedge clk);
      while (!steady && $urandom_range(99) < 9) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_packet_byte <= stream[i].data;
      in_last_byte <= stream[i].last;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      beats_sent++;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain outstanding records, then allow for the block latency
    drain = 0;
    while (pending != 0 && drain < 20000) begin
      @(negedge clk);
      drain++;
    end
    repeat (10) @(negedge clk);

    $display("run covered %0d bytes in %0d compound packets, %0d records checked",
             beats_sent, packets_built, records_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d records never arrived", fail_count, pending);
      $display("tb: failure");
    end
    $finish;
  end

  // receiver: random stalls, none in the steady window, stalled throughout a hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_ready <= 1'b0;
      else if (steady) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 9);
    end
  end

  // one long hold-off so the result path fills and the input stalls
  initial begin
    hold_off = 1'b0;
    wait (beats_sent >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog
  initial begin
    #200000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== rtcp_compound_report_parser.f =====
rtl/rcrp_pkg.sv
rtl/rcrp_walker.sv
rtl/rtcp_compound_report_parser.sv
tb/rcrp_checker.sv
tb/tb_top.sv
